[src/l2bha_pkg.sv]
// Shared types, constants and state encodings for the log2-binned histogram accumulator.
// No dependencies; every other source file but l2bha_ram imports this package.
`default_nettype none

package l2bha_pkg;

    // Default sizes of the sum tables
    localparam int NUM_OPS_DEF    = 64;
    localparam int GROUP_BINS_DEF = 16;
    localparam int SIZE_BINS_DEF  = 16;

    // Field widths
    localparam int VAL_W     = 31;
    localparam int OPC_W     = 2;
    localparam int OP_W      = 6;
    localparam int BIN_IN_W  = 4;
    localparam int BIN_W     = 5;   // holds bin numbers up to 31
    localparam int AMOUNT_W  = 40;
    localparam int SUM_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;

    localparam logic [VAL_W-1:0] FIRST_BIN_RESET = VAL_W'(7);
    localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};

    // Opcodes
    localparam logic [OPC_W-1:0] OPC_ACCUM = 2'd0;
    localparam logic [OPC_W-1:0] OPC_READ  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_ADD   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMM_FIRST_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_FIRST_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLLECT_EN     = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] comm_first_max;
        logic [VAL_W-1:0] size_first_max;
        logic             collect_en;
    } cfg_t;

    // One classified request handed from the front to the back
    typedef struct packed {
        logic                do_add;
        logic                skip;
        logic                tsel;
        logic [OP_W-1:0]     op;
        logic [BIN_W-1:0]    gbin;
        logic [BIN_W-1:0]    sbin;
        logic [AMOUNT_W-1:0] amount;
    } item_t;

    typedef enum logic {
        F_IDLE,
        F_BIN
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CALC
    } back_state_t;

endpackage

`default_nettype wire

[src/l2bha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module l2bha_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/l2bha_front.sv]
// Front end: accepts requests, clamps bin and operation numbers, bins sizes by halving.
// Depends on l2bha_pkg.
`default_nettype none

module l2bha_front #(
    parameter int NUM_OPS    = l2bha_pkg::NUM_OPS_DEF,
    parameter int GROUP_BINS = l2bha_pkg::GROUP_BINS_DEF,
    parameter int SIZE_BINS  = l2bha_pkg::SIZE_BINS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              enable,
    input  wire l2bha_pkg::cfg_t                   cfg,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [l2bha_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic [l2bha_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                                   push,
    output l2bha_pkg::item_t                       push_item,
    input  wire logic                              q_full
);
    import l2bha_pkg::*;

    localparam logic [BIN_W-1:0] G_LAST = BIN_W'(GROUP_BINS - 1);
    localparam logic [BIN_W-1:0] S_LAST = BIN_W'(SIZE_BINS - 1);
    localparam logic [OP_W-1:0]  OP_LAST = OP_W'(NUM_OPS - 1);

    front_state_t     state_reg, state_next;
    item_t            item_reg, item_next;
    logic [VAL_W-1:0] gval_reg, gval_next;
    logic [VAL_W-1:0] sval_reg, sval_next;

    // Unpacked input fields
    logic [OPC_W-1:0]    in_opcode;
    logic                in_tsel;
    logic [OP_W-1:0]     in_op;
    logic [VAL_W-1:0]    in_gsize;
    logic [VAL_W-1:0]    in_msize;
    logic [BIN_IN_W-1:0] in_gbin;
    logic [BIN_IN_W-1:0] in_sbin;
    logic [AMOUNT_W-1:0] in_amount;

    logic g_done, s_done;

    assign in_opcode = s_tuser[1:0];
    assign in_tsel   = s_tuser[2];
    assign in_op     = s_tdata[5:0];
    assign in_gsize  = s_tdata[36:6];
    assign in_msize  = s_tdata[67:37];
    assign in_gbin   = s_tdata[71:68];
    assign in_sbin   = s_tdata[75:72];
    assign in_amount = s_tdata[115:76];

    assign g_done = (gval_reg <= cfg.comm_first_max) || (item_reg.gbin == G_LAST);
    assign s_done = (sval_reg <= cfg.size_first_max) || (item_reg.sbin == S_LAST);

    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        gval_reg <= gval_next;
        sval_reg <= sval_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        gval_next  = gval_reg;
        sval_next  = sval_reg;
        s_tready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                s_tready = enable;
                if (enable && s_tvalid)
                begin
                    item_next.tsel   = in_tsel;
                    item_next.amount = in_amount;
                    item_next.op     = (32'(in_op) >= NUM_OPS) ? OP_LAST : in_op;
                    if (in_opcode == OPC_ACCUM)
                    begin
                        // Start binning from bin zero with the raw sizes
                        item_next.do_add = cfg.collect_en;
                        item_next.skip   = !cfg.collect_en;
                        item_next.gbin   = '0;
                        item_next.sbin   = '0;
                        gval_next        = in_gsize;
                        sval_next        = in_msize;
                    end
                    else
                    begin
                        // Bins are given; zero values end the halving at once
                        item_next.do_add = (in_opcode == OPC_ADD);
                        item_next.skip   = 1'b0;
                        item_next.gbin   = (32'(in_gbin) >= GROUP_BINS) ? G_LAST
                                                                        : BIN_W'(in_gbin);
                        item_next.sbin   = (32'(in_sbin) >= SIZE_BINS) ? S_LAST
                                                                       : BIN_W'(in_sbin);
                        gval_next        = '0;
                        sval_next        = '0;
                    end
                    state_next = F_BIN;
                end
            end
            F_BIN:
            begin
                if (g_done && s_done)
                begin
                    if (!q_full)
                    begin
                        push       = 1'b1;
                        state_next = F_IDLE;
                    end
                end
                else
                begin
                    // Halve each value that is still above its first-bin limit
                    if (!g_done)
                    begin
                        gval_next      = gval_reg >> 1;
                        item_next.gbin = item_reg.gbin + BIN_W'(1);
                    end
                    if (!s_done)
                    begin
                        sval_next      = sval_reg >> 1;
                        item_next.sbin = item_reg.sbin + BIN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/l2bha_queue.sv]
// Two-entry queue of classified requests between the front and the back.
// Depends on l2bha_pkg.
`default_nettype none

module l2bha_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire l2bha_pkg::item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output l2bha_pkg::item_t      head
);
    import l2bha_pkg::*;

    item_t       entry_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[src/l2bha_back.sv]
// Back end: clears the sum table after reset, then reads each entry, adds with saturation
// and writes back for adds, and holds the result. Depends on l2bha_pkg and l2bha_ram.
`default_nettype none

module l2bha_back #(
    parameter int NUM_OPS    = l2bha_pkg::NUM_OPS_DEF,
    parameter int GROUP_BINS = l2bha_pkg::GROUP_BINS_DEF,
    parameter int SIZE_BINS  = l2bha_pkg::SIZE_BINS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    output logic                                    clearing,
    input  wire logic                               head_valid,
    input  wire l2bha_pkg::item_t                   head,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [l2bha_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import l2bha_pkg::*;

    localparam int DEPTH  = 2 * NUM_OPS * GROUP_BINS * SIZE_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    item_t             cur_reg, cur_next;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  out_value_reg, out_value_next;
    logic [BIN_W-1:0]  out_gbin_reg, out_gbin_next;
    logic [BIN_W-1:0]  out_sbin_reg, out_sbin_next;
    logic              out_skip_reg, out_skip_next;
    logic              out_sat_reg, out_sat_next;

    logic [ADDR_W-1:0] head_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W:0]    sum_wide;
    logic              sum_ovf;
    logic [SUM_W-1:0]  sum_sat;
    logic              out_free;

    // Mixed-radix address: table, operation, group bin, size bin
    assign head_addr = ((ADDR_W'(head.tsel) * ADDR_W'(NUM_OPS) + ADDR_W'(head.op))
                        * ADDR_W'(GROUP_BINS) + ADDR_W'(head.gbin))
                       * ADDR_W'(SIZE_BINS) + ADDR_W'(head.sbin);

    assign sum_wide = {1'b0, ram_rdata} + (SUM_W+1)'(cur_reg.amount);
    assign sum_ovf  = sum_wide[SUM_W];
    assign sum_sat  = sum_ovf ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign out_free = !out_valid_reg || m_tready;

    // Hold the read address on the current entry while waiting on the output
    assign ram_raddr = (state_reg == B_IDLE) ? head_addr : cur_addr_reg;
    assign clearing  = (state_reg == B_CLEAR);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_sat_reg, out_skip_reg, 1'b0,
                       out_sbin_reg[3:0], out_gbin_reg[3:0], out_value_reg};

    l2bha_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        cur_addr_reg  <= cur_addr_next;
        out_value_reg <= out_value_next;
        out_gbin_reg  <= out_gbin_next;
        out_sbin_reg  <= out_sbin_next;
        out_skip_reg  <= out_skip_next;
        out_sat_reg   <= out_sat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        cur_addr_next  = cur_addr_reg;
        out_valid_next = (out_valid_reg && !m_tready);
        out_value_next = out_value_reg;
        out_gbin_next  = out_gbin_reg;
        out_sbin_next  = out_sbin_reg;
        out_skip_next  = out_skip_reg;
        out_sat_next   = out_sat_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr_reg;
        ram_wdata      = sum_sat;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop           = 1'b1;
                    cur_next      = head;
                    cur_addr_next = head_addr;
                    state_next    = B_CALC;
                end
            end
            B_CALC:
            begin
                if (out_free)
                begin
                    ram_we         = cur_reg.do_add;
                    out_valid_next = 1'b1;
                    out_value_next = cur_reg.do_add ? sum_sat : ram_rdata;
                    out_gbin_next  = cur_reg.gbin;
                    out_sbin_next  = cur_reg.sbin;
                    out_skip_next  = cur_reg.skip;
                    out_sat_next   = cur_reg.do_add && sum_ovf;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/log2_binned_histogram_accumulator_core.sv]
// Top level of the log2-binned histogram accumulator: configuration registers,
// front end, request queue and back end. Depends on l2bha_pkg and all l2bha_* modules.
`default_nettype none

// Keeps two 48-bit sum tables (collective and point-to-point), indexed by
// operation, group-size bin and message-size bin. Each request on the slave
// stream yields exactly one result on the master stream. Opcode 0 bins
// group_size and msg_size (one halving per bin until the value is at most the
// first-bin limit, stopping at the last bin) and adds amount; with collection
// disabled it only reports the entry and sets skipped_flag. Opcode 1 (and the
// unused opcode 3) reads an entry at the given bins; opcode 2 adds amount at
// the given bins. Given bins and operation numbers past the end are clamped
// to the last one. Sums saturate at 2^48-1 and set saturated.
// After reset the back end zeroes all 2*NUM_OPS*GROUP_BINS*SIZE_BINS table
// entries (32768 with the defaults), one entry a cycle; s_tready stays low
// until then, while configuration writes are taken at any time. The front end
// takes a request while idle, halves each value still above its first-bin
// limit, both at once, and hands it on once both are binned and the queue has
// room. The back end pops a request, reads its entry, then writes back the
// saturated sum for adds and loads the output register once that is free. A
// two-entry queue between them lets a binning request overlap the previous
// request's table update; a result waiting on the output holds the back end,
// then the front end once the queue fills. Write configuration only while idle.

module log2_binned_histogram_accumulator_core #(
    parameter int NUM_OPS    = l2bha_pkg::NUM_OPS_DEF,
    parameter int GROUP_BINS = l2bha_pkg::GROUP_BINS_DEF,
    parameter int SIZE_BINS  = l2bha_pkg::SIZE_BINS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [l2bha_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [l2bha_pkg::VAL_W-1:0]       cfg_data,
    // Request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata, from bit 0: op_index[5:0], group_size[36:6], msg_size[67:37],
    // group_bin_in[71:68], msg_bin_in[75:72], amount[115:76], zeros[119:116]
    input  wire logic [l2bha_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser, from bit 0: opcode[1:0], table_select[2]
    input  wire logic [l2bha_pkg::IN_USER_W-1:0]   s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata, from bit 0: entry_value[47:0], group_bin[51:48], msg_bin[55:52],
    // skipped[56], skipped_flag[57], saturated[58], zeros[63:59]
    output logic [l2bha_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import l2bha_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  clearing;
    logic  q_push, q_full, q_pop, q_head_valid;
    item_t q_push_item, q_head;

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COMM_FIRST_MAX: cfg_next.comm_first_max = cfg_data;
                REG_SIZE_FIRST_MAX: cfg_next.size_first_max = cfg_data;
                REG_COLLECT_EN:     cfg_next.collect_en     = cfg_data[0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comm_first_max <= FIRST_BIN_RESET;
            cfg_reg.size_first_max <= FIRST_BIN_RESET;
            cfg_reg.collect_en     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: take requests once the table is cleared, bin and classify
    l2bha_front #(
        .NUM_OPS    (NUM_OPS),
        .GROUP_BINS (GROUP_BINS),
        .SIZE_BINS  (SIZE_BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!clearing),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (q_push),
        .push_item (q_push_item),
        .q_full    (q_full)
    );

    // Decouple binning from the table update
    l2bha_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Back end: clear pass, then read-modify-write and result register
    l2bha_back #(
        .NUM_OPS    (NUM_OPS),
        .GROUP_BINS (GROUP_BINS),
        .SIZE_BINS  (SIZE_BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clearing   (clearing),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

[verif/log2_binned_histogram_accumulator_core_test.sv]
// Self-checking regression for log2_binned_histogram_accumulator_core: directed and random
// requests against an in-bench model of the two sum tables, with random stream idling.
// Depends on l2bha_pkg and the accumulator RTL.
`timescale 1ns / 100ps

module log2_binned_histogram_accumulator_core_test;

    import l2bha_pkg::*;

    // Opcode 3 has no name in the package; the block treats it as a read
    localparam logic [OPC_W-1:0] OPC_SPARE = 2'd3;

    // Slowest correct run: the table clear after reset, then about 1750 requests,
    // each with its worst source gap, binning, table update and sink stall, plus the
    // hold-off and the config pauses. CYCLE_LIMIT stays well above that.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RECENT_DEPTH    = 16;

    typedef struct packed {
        logic [OPC_W-1:0]    opcode;
        logic                tsel;
        logic [OP_W-1:0]     op_index;
        logic [VAL_W-1:0]    group_size;
        logic [VAL_W-1:0]    msg_size;
        logic [BIN_IN_W-1:0] group_bin_in;
        logic [BIN_IN_W-1:0] msg_bin_in;
        logic [AMOUNT_W-1:0] amount;
    } request_t;

    typedef struct packed {
        logic [SUM_W-1:0]    entry_value;
        logic [BIN_IN_W-1:0] group_bin;
        logic [BIN_IN_W-1:0] msg_bin;
        logic                skipped_flag;
        logic                saturated;
    } result_t;

    // One table entry address, kept so that reads and merges can revisit it
    typedef struct packed {
        logic                tsel;
        logic [OP_W-1:0]     op_index;
        logic [BIN_IN_W-1:0] group_bin;
        logic [BIN_IN_W-1:0] msg_bin;
    } slot_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [VAL_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tdata, from bit 0: op_index, group_size, msg_size, group_bin_in, msg_bin_in,
    // amount, zero pad
    logic [IN_DATA_W-1:0]   s_tdata;
    // s_tuser, from bit 0: opcode, table_select
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tdata, from bit 0: entry_value, group_bin, msg_bin, skipped, skipped_flag,
    // saturated, zero pad
    logic [OUT_DATA_W-1:0]  m_tdata;

    // Model of the block: sums written so far (absent means zero) and the registers
    logic [SUM_W-1:0]  entry_sums [int];
    logic [VAL_W-1:0]  comm_limit;
    logic [VAL_W-1:0]  size_limit;
    logic              collect_on;

    result_t           pending_results [$];
    slot_t             recent_slots [$];
    int unsigned       mismatch_count;
    int unsigned       cycle_count;

    // Idling controls: the sender's own flag, and the receiver's, set at clock edges
    logic              source_gaps;
    logic              sink_stalls;
    int unsigned       hold_off_ticket;
    int unsigned       hold_off_served;
    int unsigned       stall_left;

    log2_binned_histogram_accumulator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Count halvings until the value fits the first bin; stop at the last bin
    function automatic logic [BIN_IN_W-1:0] log2_bin(logic [VAL_W-1:0] value,
                                                      logic [VAL_W-1:0] first_max,
                                                      int nbins);
        int bin = 0;
        while (value > first_max && bin + 1 < nbins)
        begin
            value = value >> 1;
            bin++;
        end
        return bin[BIN_IN_W-1:0];
    endfunction

    // Apply one request to the model tables and return the result it must produce
    function automatic result_t predict_result(request_t rq);
        result_t            rs;
        int                 slot;
        logic [SUM_W:0]     total;
        logic               accumulate;
        rs = '0;
        accumulate = 1'b0;
        if (rq.opcode == OPC_ACCUM)
        begin
            rs.group_bin = log2_bin(rq.group_size, comm_limit, GROUP_BINS_DEF);
            rs.msg_bin   = log2_bin(rq.msg_size, size_limit, SIZE_BINS_DEF);
            if (collect_on)
                accumulate = 1'b1;
            else
                rs.skipped_flag = 1'b1;
        end
        else
        begin
            // Given bins always fit with sixteen bins per axis
            rs.group_bin = rq.group_bin_in;
            rs.msg_bin   = rq.msg_bin_in;
            accumulate   = (rq.opcode == OPC_ADD);
        end
        slot = ((int'(rq.tsel) * NUM_OPS_DEF + int'(rq.op_index)) * GROUP_BINS_DEF
                + int'(rs.group_bin)) * SIZE_BINS_DEF + int'(rs.msg_bin);
        rs.entry_value = entry_sums.exists(slot) ? entry_sums[slot] : '0;
        if (accumulate)
        begin
            total = {1'b0, rs.entry_value} + (SUM_W + 1)'(rq.amount);
            if (total > {1'b0, SUM_MAX})
            begin
                total        = {1'b0, SUM_MAX};
                rs.saturated = 1'b1;
            end
            rs.entry_value   = total[SUM_W-1:0];
            entry_sums[slot] = rs.entry_value;
        end
        return rs;
    endfunction

    function automatic request_t make_request(logic [OPC_W-1:0] opcode, logic tsel,
                                              logic [OP_W-1:0] op_index,
                                              logic [VAL_W-1:0] group_size,
                                              logic [VAL_W-1:0] msg_size,
                                              logic [BIN_IN_W-1:0] group_bin_in,
                                              logic [BIN_IN_W-1:0] msg_bin_in,
                                              logic [AMOUNT_W-1:0] amount);
        request_t rq;
        rq.opcode       = opcode;
        rq.tsel         = tsel;
        rq.op_index     = op_index;
        rq.group_size   = group_size;
        rq.msg_size     = msg_size;
        rq.group_bin_in = group_bin_in;
        rq.msg_bin_in   = msg_bin_in;
        rq.amount       = amount;
        return rq;
    endfunction

    // Spread sizes over every bin: a random word shifted down by a random amount
    function automatic logic [VAL_W-1:0] spread_size();
        return VAL_W'($urandom) >> $urandom_range(0, VAL_W);
    endfunction

    function automatic request_t random_request();
        request_t rq;
        slot_t    target;
        int       pick;
        pick = $urandom_range(0, 99);
        rq.opcode = (pick < 55) ? OPC_ACCUM : (pick < 75) ? OPC_ADD :
                    (pick < 95) ? OPC_READ : OPC_SPARE;
        rq.tsel = 1'($urandom_range(0, 1));
        // Keep most traffic on a few operations so entries build up
        rq.op_index = ($urandom_range(0, 9) < 7) ? OP_W'($urandom_range(0, 3))
                                                 : OP_W'($urandom_range(0, 63));
        rq.group_size   = spread_size();
        rq.msg_size     = spread_size();
        rq.group_bin_in = BIN_IN_W'($urandom_range(0, 15));
        rq.msg_bin_in   = BIN_IN_W'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       rq.amount = AMOUNT_W'({$urandom, $urandom});
            1:       rq.amount = AMOUNT_W'({$urandom, $urandom}) >> $urandom_range(0, 39);
            2:       rq.amount = AMOUNT_W'($urandom_range(0, 65535));
            default: rq.amount = '0;
        endcase
        // Point most reads and merges at entries that already hold a sum
        if (rq.opcode != OPC_ACCUM && recent_slots.size() > 0 && $urandom_range(0, 9) < 7)
        begin
            target          = recent_slots[$urandom_range(0, recent_slots.size() - 1)];
            rq.tsel         = target.tsel;
            rq.op_index     = target.op_index;
            rq.group_bin_in = target.group_bin;
            rq.msg_bin_in   = target.msg_bin;
        end
        return rq;
    endfunction

    // Offer one request after an optional gap, hold it until taken, then predict it
    task automatic send_request(input request_t rq);
        int      gap;
        result_t rs;
        slot_t   touched;
        gap = source_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, rq.amount, rq.msg_bin_in, rq.group_bin_in,
                     rq.msg_size, rq.group_size, rq.op_index};
        s_tuser  <= {rq.tsel, rq.opcode};
        do
            @(posedge clk);
        while (!s_tready);
        rs = predict_result(rq);
        pending_results.push_back(rs);
        touched = {rq.tsel, rq.op_index, rs.group_bin, rs.msg_bin};
        recent_slots.push_back(touched);
        if (recent_slots.size() > RECENT_DEPTH)
            void'(recent_slots.pop_front());
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers back to back; call only while idle
    task automatic configure(input logic [VAL_W-1:0] comm, input logic [VAL_W-1:0] size,
                             input logic enable);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COMM_FIRST_MAX;
        cfg_data  <= comm;
        @(posedge clk);
        cfg_index <= REG_SIZE_FIRST_MAX;
        cfg_data  <= size;
        @(posedge clk);
        cfg_index <= REG_COLLECT_EN;
        cfg_data  <= VAL_W'(enable);
        @(posedge clk);
        cfg_we     <= 1'b0;
        comm_limit = comm;
        size_limit = size;
        collect_on = enable;
    endtask

    task automatic set_idling(input logic gaps, input logic stalls);
        source_gaps = gaps;
        sink_stalls <= stalls;
    endtask

    // Every opcode, both tables, field extremes, under the reset configuration
    task automatic test_opcodes();
        set_idling(1'b1, 1'b1);
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, '0, '0, 4'd0, 4'd0, '0));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, 31'd7, 31'd8, 4'd0, 4'd0, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, '1, '1, 4'd0, 4'd0, '1));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, 31'd8, 31'd15, 4'd0, 4'd0, 40'd5));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, 31'd16, 31'd31, 4'd0, 4'd0, 40'd9));
        send_request(make_request(OPC_READ, 1'b0, 6'd0, '0, '0, 4'd0, 4'd1, '0));
        send_request(make_request(OPC_READ, 1'b0, 6'd0, '0, '0, 4'd15, 4'd15, '1));
        send_request(make_request(OPC_READ, 1'b0, 6'd0, '1, '1, 4'd2, 4'd2, '0));
        send_request(make_request(OPC_ADD, 1'b1, 6'd63, '0, '0, 4'd15, 4'd0, '1));
        send_request(make_request(OPC_SPARE, 1'b1, 6'd63, '1, '1, 4'd15, 4'd0, '1));
        send_request(make_request(OPC_ADD, 1'b1, 6'd63, '0, '0, 4'd0, 4'd15, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b1, 6'd63, 31'd100, 31'd1, 4'd0, 4'd0, 40'd3));
        send_request(make_request(OPC_READ, 1'b1, 6'd63, '0, '0, 4'd3, 4'd0, '0));
        send_request(make_request(OPC_ADD, 1'b0, 6'd0, '0, '0, 4'd0, 4'd1, 40'd2));
        drain();
    endtask

    // First-bin limits at both extremes and at a middle value
    task automatic test_bin_limits();
        configure('0, '1, 1'b1);
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd5, '0, '1, 4'd0, 4'd0, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd5, 31'd1, '0, 4'd0, 4'd0, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd5, '1, '1, 4'd0, 4'd0, 40'd1));
        drain();
        configure('1, '0, 1'b1);
        send_request(make_request(OPC_ACCUM, 1'b1, 6'd6, '1, '0, 4'd0, 4'd0, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b1, 6'd6, '0, 31'd2, 4'd0, 4'd0, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b1, 6'd6, '1, '1, 4'd0, 4'd0, 40'd1));
        drain();
        configure(31'd3, 31'd100, 1'b1);
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd7, 31'd4, 31'd101, 4'd0, 4'd0, 40'd1));
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd7, 31'd3, 31'd100, 4'd0, 4'd0, 40'd1));
        drain();
    endtask

    // Collection off: accumulate reports the entry untouched; merges still apply
    task automatic test_collect_disabled();
        configure(31'd7, 31'd7, 1'b0);
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, '1, '1, 4'd0, 4'd0, '1));
        send_request(make_request(OPC_ACCUM, 1'b1, 6'd9, 31'd50, 31'd3, 4'd0, 4'd0, 40'd7));
        send_request(make_request(OPC_ADD, 1'b0, 6'd0, '0, '0, 4'd15, 4'd15, 40'd11));
        send_request(make_request(OPC_READ, 1'b0, 6'd0, '0, '0, 4'd15, 4'd15, '0));
        drain();
        configure(31'd7, 31'd7, 1'b1);
        send_request(make_request(OPC_ACCUM, 1'b0, 6'd0, '1, '1, 4'd0, 4'd0, 40'd1));
        drain();
    endtask

    // Pump one entry past 2^48-1 with binned and given-bin adds, then add zero
    task automatic test_saturation();
        set_idling(1'b0, 1'b1);
        for (int i = 0; i < 260; i++)
        begin
            if (i % 2 == 0)
                send_request(make_request(OPC_ADD, 1'b1, 6'd63, '0, '0, 4'd15, 4'd15, '1));
            else
                send_request(make_request(OPC_ACCUM, 1'b1, 6'd63, '1, '1, 4'd0, 4'd0, '1));
        end
        send_request(make_request(OPC_ADD, 1'b1, 6'd63, '0, '0, 4'd15, 4'd15, '0));
        send_request(make_request(OPC_READ, 1'b1, 6'd63, '0, '0, 4'd15, 4'd15, '1));
        drain();
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the internal queue fills and the block stalls its input
    task automatic test_backpressure();
        set_idling(1'b0, 1'b0);
        hold_off_ticket <= hold_off_ticket + 1;
        for (int i = 0; i < 40; i++)
            send_request(random_request());
        drain();
    endtask

    // Random phases, each under its own configuration and idling mix
    task automatic test_random();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: configure(31'd7, 31'd7, 1'b1);
                1: configure('0, '1, 1'b1);
                2: configure('1, '0, 1'b1);
                3: configure(VAL_W'($urandom_range(0, 300)), VAL_W'($urandom_range(0, 300)),
                             1'b0);
                4: configure(VAL_W'($urandom), VAL_W'($urandom), 1'b1);
                default: configure(VAL_W'($urandom_range(0, 63)),
                                   VAL_W'($urandom_range(0, 63)), 1'b1);
            endcase
            set_idling(phase % 2 == 0, phase % 3 != 2);
            for (int i = 0; i < 230; i++)
                send_request(random_request());
            drain();
        end
    endtask

    // Result side: random stall after each accepted result while stalls are on, plus the long hold-off
    always @(posedge clk)
    begin
        int unsigned sink_wait;
        if (hold_off_ticket != hold_off_served)
        begin
            hold_off_served <= hold_off_ticket;
            stall_left      <= HOLD_OFF_CYCLES;
            m_tready        <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            if (sink_stalls)
            begin
                // A draw of zero keeps ready high for the next result
                sink_wait  = $urandom_range(0, 15);
                stall_left <= sink_wait;
                m_tready   <= (sink_wait == 0);
            end
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest prediction, field by field
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: m_tdata=%h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[47:0] !== want.entry_value)
                begin
                    $error("entry_value: expected %0d, got %0d", want.entry_value,
                           m_tdata[47:0]);
                    mismatch_count++;
                end
                if (m_tdata[51:48] !== want.group_bin)
                begin
                    $error("group_bin: expected %0d, got %0d", want.group_bin, m_tdata[51:48]);
                    mismatch_count++;
                end
                if (m_tdata[55:52] !== want.msg_bin)
                begin
                    $error("msg_bin: expected %0d, got %0d", want.msg_bin, m_tdata[55:52]);
                    mismatch_count++;
                end
                if (m_tdata[56] !== 1'b0)
                begin
                    $error("skipped: expected 0, got %b", m_tdata[56]);
                    mismatch_count++;
                end
                if (m_tdata[57] !== want.skipped_flag)
                begin
                    $error("skipped_flag: expected %b, got %b", want.skipped_flag, m_tdata[57]);
                    mismatch_count++;
                end
                if (m_tdata[58] !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b", want.saturated, m_tdata[58]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("log2_binned_histogram_accumulator_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        source_gaps     = 1'b1;
        sink_stalls     = 1'b1;
        hold_off_ticket = 0;
        hold_off_served = 0;
        stall_left      = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        comm_limit      = FIRST_BIN_RESET;
        size_limit      = FIRST_BIN_RESET;
        collect_on      = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // The table clear after reset keeps s_tready low; the first request waits it out
        @(posedge clk);

        test_opcodes();
        test_bin_limits();
        test_collect_disabled();
        test_saturation();
        test_backpressure();
        test_random();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("log2_binned_histogram_accumulator_core regression: pass");
        else
            $display("log2_binned_histogram_accumulator_core regression: fail");
        $finish;
    end

endmodule

[files.f]
src/l2bha_pkg.sv
src/l2bha_ram.sv
src/l2bha_front.sv
src/l2bha_queue.sv
src/l2bha_back.sv
src/log2_binned_histogram_accumulator_core.sv
verif/log2_binned_histogram_accumulator_core_test.sv
